// ----- rtl/ahc_pkg.sv -----
package ahc_pkg;

  localparam int CountW = 29;
  localparam int SymW   = 8;
  localparam int CodeW  = 64;
  localparam int LenW   = 7;

  localparam logic [CountW-1:0] ThreshReset = 29'h1000_0000;

  typedef logic [CountW-1:0] count_t;
  typedef logic [SymW-1:0]   sym_t;
  typedef logic [CodeW-1:0]  code_t;
  typedef logic [LenW-1:0]   len_t;

endpackage

// ----- rtl/ahc_if.sv -----
interface ahc_in_if;
  logic                valid;
  logic                ready;
  logic                func;
  ahc_pkg::sym_t       symbol_in;
  ahc_pkg::code_t      bit_window;

  modport source (output valid, func, symbol_in, bit_window, input ready);
  modport sink   (input valid, func, symbol_in, bit_window, output ready);
endinterface

interface ahc_out_if;
  logic                valid;
  logic                ready;
  ahc_pkg::sym_t       symbol_out;
  ahc_pkg::code_t      code_word;
  ahc_pkg::len_t       code_length;

  modport source (output valid, symbol_out, code_word, code_length, input ready);
  modport sink   (input valid, symbol_out, code_word, code_length, output ready);
endinterface

// ----- rtl/ahc_ram.sv -----
module ahc_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // read-first: a read in the same cycle as a write to that address returns the old data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- rtl/adaptive_huffman_byte_coder.sv -----
// channel   | dir | handshake     | word
// ----------+-----+---------------+-----------------------------------------
// in_i      | in  | valid/ready   | func, symbol_in, bit_window
// out_o     | out | valid/ready   | symbol_out, code_word, code_length
// cfg       | in  | cfg_we_i      | cfg_data_i (rescale threshold)
//
// one word at a time; encode walks the leaf path up through the parent memory,
// decode walks the root path down through the node memory, then the count
// update climbs the leaf path, scanning upward for a swap at each level (single
// read port of the node memory). a rebuild halves, pairs and relinks the tree.
// after reset a clearing pass builds the tree with in_i.ready low. a finished
// word waits in the output register while the next word is taken; a stalled
// output holds the block only at its end.
module adaptive_huffman_byte_coder #(
  parameter int SYMBOLS     = 256,
  parameter int WINDOW_BITS = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  ahc_pkg::count_t        cfg_data_i,
  ahc_in_if.sink                 in_i,
  ahc_out_if.source              out_o
);

  localparam int Nodes   = 2 * SYMBOLS - 1;
  localparam int Root    = Nodes - 1;
  localparam int IW      = $clog2(3 * SYMBOLS - 1);
  localparam int AW      = $clog2(Nodes);
  localparam int CW      = ahc_pkg::CountW;
  localparam int NW      = IW + CW;

  localparam logic [IW-1:0] NodesI   = IW'(Nodes);
  localparam logic [IW-1:0] RootI    = IW'(Root);
  localparam logic [IW-1:0] SymI     = IW'(SYMBOLS);
  localparam logic [IW-1:0] LeafEndI = IW'(Nodes + SYMBOLS - 1);

  typedef enum logic [4:0] {
    ST_INIT, ST_IDLE, ST_ENC_REQ, ST_ENC_WAIT, ST_DEC_REQ, ST_DEC_WAIT,
    ST_UPD_REQ, ST_UPD_CHK, ST_LEAF_REQ, ST_P_REQ, ST_P_WAIT, ST_C_REQ,
    ST_C_WAIT, ST_N_WAIT, ST_SWAP_A, ST_SWAP_B, ST_P1_REQ, ST_P1_WAIT,
    ST_P2_RA, ST_P2_RB, ST_P2_SUM, ST_P2_CREQ, ST_P2_CMP, ST_P3_REQ,
    ST_P3_WAIT, ST_FINISH
  } state_e;

  state_e state_q, state_d;

  logic [IW-1:0] i_q, i_d, j_q, j_d, k_q, k_d, c_q, c_d;
  logic [IW-1:0] l_q, l_d, s_q, s_d, node_q, node_d;
  logic [IW-1:0] wc_child_q, wc_child_d, ws_child_q, ws_child_d;
  ahc_pkg::count_t f_q, f_d, cnt_q, cnt_d, ws_cnt_q, ws_cnt_d, thr_q;
  logic found_q, found_d, first_q, first_d, rb_upd_q, rb_upd_d;
  ahc_pkg::sym_t  sym_q, sym_d;
  logic [WINDOW_BITS-1:0] win_q, win_d;
  ahc_pkg::code_t code_q, code_d;
  ahc_pkg::len_t  len_q, len_d;

  logic           out_valid_q, out_valid_d;
  ahc_pkg::sym_t  out_sym_q, out_sym_d;
  ahc_pkg::code_t out_code_q, out_code_d;
  ahc_pkg::len_t  out_len_q, out_len_d;

  // node memory holds {child, count}, parent memory holds one link per pair and per leaf
  logic          n_we;
  logic [AW-1:0] n_waddr, n_raddr;
  logic [NW-1:0] n_wdata, n_rdata;
  logic          p_we;
  logic [AW-1:0] p_waddr, p_raddr, p_wdata, p_rdata;

  ahc_ram #(.Width(NW), .Depth(Nodes)) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (n_waddr),
    .wdata_i (n_wdata),
    .raddr_i (n_raddr),
    .rdata_o (n_rdata)
  );

  ahc_ram #(.Width(AW), .Depth(Nodes)) u_parent_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (p_waddr),
    .wdata_i (p_wdata),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  // sibling pairs share one link entry, leaf links follow them
  function automatic logic [AW-1:0] paddr(input logic [IW-1:0] n);
    logic [IW-1:0] t;
    t = n - NodesI + SymI - IW'(1);
    if (n < NodesI) begin
      return AW'(n >> 1);
    end
    return AW'(t);
  endfunction

  logic [IW-1:0]   rd_child, p_node, dec_nxt, dec_off;
  ahc_pkg::count_t rd_cnt, cnt_inc, half;
  logic [CW:0]     cnt_ext;
  ahc_pkg::sym_t   in_sym, dec_sym;

  assign rd_child = n_rdata[CW +: IW];
  assign rd_cnt   = n_rdata[CW-1:0];
  assign p_node   = IW'(p_rdata);
  assign cnt_inc  = rd_cnt + CW'(1);
  assign cnt_ext  = {1'b0, rd_cnt} + (CW+1)'(1);
  assign half     = cnt_ext[CW:1];
  assign dec_nxt  = rd_child + IW'(win_q[0]);
  assign dec_off  = rd_child - NodesI;
  assign dec_sym  = (dec_off >= SymI) ? ahc_pkg::SymW'(SYMBOLS - 1)
                                      : ahc_pkg::SymW'(dec_off);
  assign in_sym   = ({1'b0, in_i.symbol_in} >= (ahc_pkg::SymW+1)'(SYMBOLS))
                    ? ahc_pkg::SymW'(SYMBOLS - 1) : in_i.symbol_in;

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.symbol_out  = out_sym_q;
  assign out_o.code_word   = out_code_q;
  assign out_o.code_length = out_len_q;

  always_comb begin
    state_d     = state_q;
    i_d         = i_q;
    j_d         = j_q;
    k_d         = k_q;
    c_d         = c_q;
    l_d         = l_q;
    s_d         = s_q;
    node_d      = node_q;
    wc_child_d  = wc_child_q;
    ws_child_d  = ws_child_q;
    f_d         = f_q;
    cnt_d       = cnt_q;
    ws_cnt_d    = ws_cnt_q;
    found_d     = found_q;
    first_d     = first_q;
    rb_upd_d    = rb_upd_q;
    sym_d       = sym_q;
    win_d       = win_q;
    code_d      = code_q;
    len_d       = len_q;
    out_valid_d = out_valid_q;
    out_sym_d   = out_sym_q;
    out_code_d  = out_code_q;
    out_len_d   = out_len_q;
    n_raddr     = '0;
    n_we        = 1'b0;
    n_waddr     = '0;
    n_wdata     = '0;
    p_raddr     = '0;
    p_we        = 1'b0;
    p_waddr     = '0;
    p_wdata     = '0;

    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_INIT: begin
        n_we    = 1'b1;
        n_waddr = AW'(i_q);
        n_wdata = {NodesI + i_q, CW'(1)};
        if (i_q == SymI - IW'(1)) begin
          i_d      = '0;
          j_d      = SymI;
          rb_upd_d = 1'b0;
          state_d  = ST_P2_RA;
        end else begin
          i_d = i_q + IW'(1);
        end
      end
      ST_IDLE: begin
        if (in_i.valid) begin
          sym_d   = in_sym;
          win_d   = in_i.bit_window[WINDOW_BITS-1:0];
          code_d  = '0;
          len_d   = '0;
          first_d = 1'b1;
          if (in_i.func) begin
            node_d  = RootI;
            state_d = ST_DEC_REQ;
          end else begin
            node_d  = NodesI + IW'(in_sym);
            state_d = ST_ENC_REQ;
          end
        end
      end
      ST_ENC_REQ: begin
        p_raddr = paddr(node_q);
        state_d = ST_ENC_WAIT;
      end
      ST_ENC_WAIT: begin
        // the first link is shifted in even when it is the root
        if (first_q || p_node != RootI) begin
          code_d = {code_q[ahc_pkg::CodeW-2:0], p_rdata[0]};
          len_d  = len_q + ahc_pkg::LenW'(1);
        end
        first_d = 1'b0;
        if (p_node == RootI) begin
          state_d = ST_UPD_REQ;
        end else begin
          node_d  = p_node;
          state_d = ST_ENC_REQ;
        end
      end
      ST_DEC_REQ: begin
        n_raddr = AW'(node_q);
        state_d = ST_DEC_WAIT;
      end
      ST_DEC_WAIT: begin
        if (rd_child >= NodesI) begin
          sym_d   = dec_sym;
          state_d = ST_UPD_REQ;
        end else begin
          win_d   = win_q >> 1;
          len_d   = len_q + ahc_pkg::LenW'(1);
          node_d  = (dec_nxt < NodesI) ? dec_nxt : RootI;
          state_d = ST_DEC_REQ;
        end
      end
      ST_UPD_REQ: begin
        n_raddr = AW'(RootI);
        state_d = ST_UPD_CHK;
      end
      ST_UPD_CHK: begin
        if (rd_cnt >= thr_q) begin
          rb_upd_d = 1'b1;
          i_d      = '0;
          j_d      = '0;
          state_d  = ST_P1_REQ;
        end else begin
          state_d = ST_LEAF_REQ;
        end
      end
      ST_LEAF_REQ: begin
        p_raddr = paddr(NodesI + IW'(sym_q));
        state_d = ST_P_WAIT;
      end
      ST_P_REQ: begin
        p_raddr = paddr(c_q);
        state_d = ST_P_WAIT;
      end
      ST_P_WAIT: begin
        c_d     = p_node;
        state_d = ST_C_REQ;
      end
      ST_C_REQ: begin
        n_raddr = AW'(c_q);
        state_d = ST_C_WAIT;
      end
      ST_C_WAIT: begin
        wc_child_d = rd_child;
        cnt_d      = cnt_inc;
        found_d    = 1'b0;
        if (c_q < RootI) begin
          n_raddr = AW'(c_q + IW'(1));
          l_d     = c_q + IW'(1);
          state_d = ST_N_WAIT;
        end else begin
          n_we    = 1'b1;
          n_waddr = AW'(c_q);
          n_wdata = {rd_child, cnt_inc};
          state_d = ST_FINISH;
        end
      end
      ST_N_WAIT: begin
        // scan upward for the last node whose count the new count exceeds
        if (cnt_q > rd_cnt) begin
          s_d        = l_q;
          ws_child_d = rd_child;
          ws_cnt_d   = rd_cnt;
          found_d    = 1'b1;
          if (l_q < RootI) begin
            n_raddr = AW'(l_q + IW'(1));
            l_d     = l_q + IW'(1);
          end else begin
            state_d = ST_SWAP_A;
          end
        end else if (found_q) begin
          state_d = ST_SWAP_A;
        end else begin
          n_we    = 1'b1;
          n_waddr = AW'(c_q);
          n_wdata = {wc_child_q, cnt_q};
          state_d = ST_P_REQ;
        end
      end
      ST_SWAP_A: begin
        n_we    = 1'b1;
        n_waddr = AW'(c_q);
        n_wdata = {ws_child_q, ws_cnt_q};
        p_we    = (wc_child_q <= LeafEndI);
        p_waddr = paddr(wc_child_q);
        p_wdata = AW'(s_q);
        state_d = ST_SWAP_B;
      end
      ST_SWAP_B: begin
        n_we    = 1'b1;
        n_waddr = AW'(s_q);
        n_wdata = {wc_child_q, cnt_q};
        p_we    = (ws_child_q <= LeafEndI);
        p_waddr = paddr(ws_child_q);
        p_wdata = AW'(c_q);
        c_d     = s_q;
        state_d = (s_q == RootI) ? ST_FINISH : ST_P_REQ;
      end
      // rebuild, first pass: halve the leaves and pack them to the bottom
      ST_P1_REQ: begin
        n_raddr = AW'(i_q);
        state_d = ST_P1_WAIT;
      end
      ST_P1_WAIT: begin
        if (rd_child >= NodesI) begin
          n_we    = 1'b1;
          n_waddr = AW'(j_q);
          n_wdata = {rd_child, half};
          j_d     = j_q + IW'(1);
        end
        if (i_q == RootI) begin
          i_d     = '0;
          j_d     = SymI;
          state_d = ST_P2_RA;
        end else begin
          i_d     = i_q + IW'(1);
          state_d = ST_P1_REQ;
        end
      end
      // second pass: pair up and insertion-sort the sums
      ST_P2_RA: begin
        if (j_q == NodesI) begin
          i_d     = '0;
          state_d = ST_P3_REQ;
        end else begin
          n_raddr = AW'(i_q);
          state_d = ST_P2_RB;
        end
      end
      ST_P2_RB: begin
        f_d     = rd_cnt;
        n_raddr = AW'(i_q + IW'(1));
        state_d = ST_P2_SUM;
      end
      ST_P2_SUM: begin
        f_d     = f_q + rd_cnt;
        k_d     = j_q;
        state_d = ST_P2_CREQ;
      end
      ST_P2_CREQ: begin
        if (k_q == '0) begin
          n_we    = 1'b1;
          n_waddr = AW'(k_q);
          n_wdata = {i_q, f_q};
          i_d     = i_q + IW'(2);
          j_d     = j_q + IW'(1);
          state_d = ST_P2_RA;
        end else begin
          n_raddr = AW'(k_q - IW'(1));
          state_d = ST_P2_CMP;
        end
      end
      ST_P2_CMP: begin
        n_we    = 1'b1;
        n_waddr = AW'(k_q);
        if (f_q < rd_cnt) begin
          n_wdata = n_rdata;
          k_d     = k_q - IW'(1);
          state_d = ST_P2_CREQ;
        end else begin
          n_wdata = {i_q, f_q};
          i_d     = i_q + IW'(2);
          j_d     = j_q + IW'(1);
          state_d = ST_P2_RA;
        end
      end
      // third pass: relink parents
      ST_P3_REQ: begin
        n_raddr = AW'(i_q);
        state_d = ST_P3_WAIT;
      end
      ST_P3_WAIT: begin
        p_we    = (rd_child <= LeafEndI);
        p_waddr = paddr(rd_child);
        p_wdata = AW'(i_q);
        if (i_q == RootI) begin
          state_d = rb_upd_q ? ST_LEAF_REQ : ST_IDLE;
        end else begin
          i_d     = i_q + IW'(1);
          state_d = ST_P3_REQ;
        end
      end
      ST_FINISH: begin
        if (!out_valid_q || out_o.ready) begin
          out_valid_d = 1'b1;
          out_sym_d   = sym_q;
          out_code_d  = code_q;
          out_len_d   = len_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      c_q         <= '0;
      l_q         <= '0;
      s_q         <= '0;
      node_q      <= '0;
      wc_child_q  <= '0;
      ws_child_q  <= '0;
      f_q         <= '0;
      cnt_q       <= '0;
      ws_cnt_q    <= '0;
      found_q     <= 1'b0;
      first_q     <= 1'b0;
      rb_upd_q    <= 1'b0;
      sym_q       <= '0;
      win_q       <= '0;
      code_q      <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
      out_sym_q   <= '0;
      out_code_q  <= '0;
      out_len_q   <= '0;
      thr_q       <= ahc_pkg::ThreshReset;
    end else begin
      state_q     <= state_d;
      i_q         <= i_d;
      j_q         <= j_d;
      k_q         <= k_d;
      c_q         <= c_d;
      l_q         <= l_d;
      s_q         <= s_d;
      node_q      <= node_d;
      wc_child_q  <= wc_child_d;
      ws_child_q  <= ws_child_d;
      f_q         <= f_d;
      cnt_q       <= cnt_d;
      ws_cnt_q    <= ws_cnt_d;
      found_q     <= found_d;
      first_q     <= first_d;
      rb_upd_q    <= rb_upd_d;
      sym_q       <= sym_d;
      win_q       <= win_d;
      code_q      <= code_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
      out_sym_q   <= out_sym_d;
      out_code_q  <= out_code_d;
      out_len_q   <= out_len_d;
      if (cfg_we_i) begin
        thr_q <= cfg_data_i;
      end
    end
  end

  a_node_waddr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    n_we |-> (n_waddr <= AW'(Root)))
    else $error("node memory write beyond the tree");

  a_walk_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_C_REQ) |-> (c_q < NodesI))
    else $error("update walk left the node range");

  a_out_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_FINISH))
    else $error("result word raised outside the finish step");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> (state_q != ST_IDLE))
    else $error("accepted word did not start work");

endmodule

// ----- tb/sv/adaptive_huffman_byte_coder_checker.sv -----
module adaptive_huffman_byte_coder_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  ahc_pkg::count_t cfg_data_i,
  ahc_in_if               in_mon,
  ahc_out_if              out_mon,
  output int              fail_count_o,
  output int              pending_o,
  output int              words_checked_o
);
  import ahc_pkg::*;

  localparam int Syms  = 256;
  localparam int Nodes = 2 * Syms - 1;
  localparam int Root  = Nodes - 1;
  localparam int Win   = 64;
  localparam logic [31:0] CountMask = 32'h1FFF_FFFF;

  typedef struct packed {
    sym_t  sym;
    code_t code;
    len_t  len;
  } coded_word_t;

  logic [9:0]  child_q  [Nodes];
  logic [9:0]  parent_q [Nodes + Syms];
  logic [31:0] weight_q [Nodes + 1];
  logic [31:0] threshold_q;
  coded_word_t expected_words [$];

  assign pending_o = expected_words.size();

  function automatic void tree_reset();
    int e;
    threshold_q = 32'(ThreshReset);
    foreach (parent_q[i]) parent_q[i] = '0;
    for (int i = 0; i < Syms; i++) begin
      child_q[i] = 10'(Nodes + i);
      parent_q[Nodes + i] = 10'(i);
      weight_q[i] = 1;
    end
    e = Syms;
    for (int i = 0; e < Nodes; i += 2) begin
      child_q[e] = 10'(i);
      parent_q[i] = 10'(e);
      parent_q[i + 1] = 10'(e);
      weight_q[e] = weight_q[i] + weight_q[i + 1];
      e++;
    end
    parent_q[Root] = '0;
    weight_q[Nodes] = CountMask;
  endfunction

  function automatic void tree_rebuild();
    int j, k;
    logic [31:0] f;
    j = 0;
    for (int i = 0; i < Nodes; i++) begin
      if (child_q[i] >= Nodes && j < Nodes) begin
        weight_q[j] = (weight_q[i] + 1) >> 1;
        child_q[j] = child_q[i];
        j++;
      end
    end
    j = Syms;
    for (int i = 0; j < Nodes; i += 2) begin
      f = weight_q[i] + weight_q[i + 1];
      k = j;
      while (k > 0 && f < weight_q[k - 1]) k--;
      for (int m = j; m > k; m--) begin
        weight_q[m] = weight_q[m - 1];
        child_q[m] = child_q[m - 1];
      end
      weight_q[k] = f;
      child_q[k] = 10'(i);
      j++;
    end
    for (int i = 0; i < Nodes; i++) begin
      k = child_q[i];
      if (k < Nodes + Syms) begin
        parent_q[k] = 10'(i);
        if (k < Nodes - 1) parent_q[k + 1] = 10'(i);
      end
    end
    parent_q[Root] = '0;
  endfunction

  function automatic void node_swap(int a, int b);
    int ca, cb;
    logic [31:0] t;
    ca = child_q[a];
    cb = child_q[b];
    if (ca < Nodes + Syms) begin
      parent_q[ca] = 10'(b);
      if (ca < Nodes - 1) parent_q[ca + 1] = 10'(b);
    end
    if (cb < Nodes + Syms) begin
      parent_q[cb] = 10'(a);
      if (cb < Nodes - 1) parent_q[cb + 1] = 10'(a);
    end
    child_q[a] = 10'(cb);
    child_q[b] = 10'(ca);
    t = weight_q[a];
    weight_q[a] = weight_q[b];
    weight_q[b] = t;
  endfunction

  function automatic void bump_path(int sym);
    int c, l;
    logic [31:0] k;
    if (weight_q[Root] >= threshold_q) tree_rebuild();
    c = parent_q[Nodes + sym];
    for (int guard = 0; guard < Nodes && c < Nodes; guard++) begin
      k = (weight_q[c] + 1) & CountMask;
      weight_q[c] = k;
      if (c < Root && k > weight_q[c + 1]) begin
        l = c + 1;
        while (l < Root && k > weight_q[l + 1]) l++;
        node_swap(c, l);
        c = l;
      end
      if (c == Root) break;
      c = parent_q[c];
    end
  endfunction

  function automatic coded_word_t code_symbol(logic func, sym_t sym_in, code_t window);
    coded_word_t r;
    int node, len, sym, idx;
    logic [63:0] code;
    len = 0;
    code = '0;
    if (!func) begin
      sym = sym_in;
      node = parent_q[Nodes + sym];
      for (int guard = 0; guard < Nodes && node < Nodes; guard++) begin
        code = {code[62:0], 1'(node)};
        len++;
        if (node == Root) break;
        node = parent_q[node];
        if (node == Root) break;
      end
    end else begin
      node = child_q[Root];
      for (int guard = 0; guard < Nodes && node < Nodes; guard++) begin
        idx = node + ((len < Win) ? int'(window[len]) : 0);
        len++;
        node = child_q[(idx < Nodes) ? idx : Root];
      end
      sym = (node >= Nodes) ? node - Nodes : 0;
      if (sym >= Syms) sym = Syms - 1;
    end
    bump_path(sym);
    r.sym = sym_t'(sym);
    r.code = code;
    r.len = len_t'(len);
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("%0t: %s mismatch, got %h expected %h", $realtime, what, got, want);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    coded_word_t w;
    if (!rst_ni) begin
      tree_reset();
      expected_words.delete();
      fail_count_o = 0;
      words_checked_o = 0;
    end else begin
      if (cfg_we_i) threshold_q = 32'(cfg_data_i);
      if (out_mon.valid && out_mon.ready) begin
        if (expected_words.size() == 0) begin
          report("unexpected word", 64'(out_mon.symbol_out), 64'(0));
        end else begin
          w = expected_words.pop_front();
          if (out_mon.symbol_out !== w.sym)
            report("symbol", 64'(out_mon.symbol_out), 64'(w.sym));
          if (out_mon.code_word !== w.code) report("code word", out_mon.code_word, w.code);
          if (out_mon.code_length !== w.len)
            report("code length", 64'(out_mon.code_length), 64'(w.len));
          words_checked_o++;
        end
      end
      if (in_mon.valid && in_mon.ready)
        expected_words.push_back(code_symbol(in_mon.func, in_mon.symbol_in,
                                             in_mon.bit_window));
    end
  end

endmodule

// ----- tb/sv/adaptive_huffman_byte_coder_test.sv -----
module adaptive_huffman_byte_coder_test;
  import ahc_pkg::*;

  logic   clk_i;
  logic   rst_ni;
  logic   cfg_we_i;
  count_t cfg_data_i;
  int     fail_count, pending, words_checked;
  int     send_idle_pct, recv_stall_pct;
  int     encodes, decodes, settings;

  ahc_in_if  in_if ();
  ahc_out_if out_if ();

  adaptive_huffman_byte_coder u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  adaptive_huffman_byte_coder_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_data_i      (cfg_data_i),
    .in_mon          (in_if),
    .out_mon         (out_if),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .words_checked_o (words_checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #500_000_000;
    $display("timeout with %0d words outstanding", pending);
    $display("Simulation FAILED");
    $finish;
  end

  // output side stalls at random
  always @(negedge clk_i) begin
    out_if.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  task automatic send_word(logic func, sym_t sym, code_t window);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid      <= 1'b1;
    in_if.func       <= func;
    in_if.symbol_in  <= sym;
    in_if.bit_window <= window;
    do @(posedge clk_i); while (!in_if.ready);
    @(negedge clk_i);
    if (func) decodes++;
    else encodes++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_threshold(count_t value);
    drain();
    cfg_we_i   <= 1'b1;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    settings++;
  endtask

  function automatic code_t random_window();
    return {$urandom(), $urandom()};
  endfunction

  // skewed symbols so that the tree deepens and nodes get swapped
  task automatic random_words(int n, int phase);
    sym_t  sym;
    int    hot;
    for (int i = 0; i < n; i++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 47; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 47; end
        default: begin send_idle_pct = 15; recv_stall_pct = 15; end
      endcase
      hot = $urandom_range(99);
      if (hot < 50) sym = sym_t'($urandom_range(7));
      else if (hot < 70) sym = sym_t'(8'hF8 + $urandom_range(7));
      else sym = sym_t'($urandom());
      if (i == n / 2 && phase == 2) drain();
      send_word($urandom_range(99) < 35, sym, random_window());
    end
  endtask

  initial begin
    in_if.valid      = 1'b0;
    in_if.func       = 1'b0;
    in_if.symbol_in  = '0;
    in_if.bit_window = '0;
    out_if.ready     = 1'b0;
    cfg_we_i         = 1'b0;
    cfg_data_i       = '0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    encodes = 0; decodes = 0; settings = 0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed words on the balanced tree
    send_word(1'b0, 8'h00, '1);
    send_word(1'b0, 8'hFF, '0);
    send_word(1'b0, 8'h80, '0);
    send_word(1'b0, 8'h01, '0);
    send_word(1'b1, 8'hFF, '0);
    send_word(1'b1, 8'h00, '1);
    send_word(1'b1, 8'h3C, 64'hAAAA_AAAA_AAAA_AAAA);
    send_word(1'b1, 8'hC3, 64'h5555_5555_5555_5555);
    send_word(1'b0, 8'hAA, 64'h5555_5555_5555_5555);
    send_word(1'b0, 8'h55, '1);
    send_word(1'b1, 8'h00, 64'h8000_0000_0000_0001);
    send_word(1'b0, 8'h00, '0);
    send_word(1'b1, 8'h00, '0);
    send_word(1'b0, 8'h7F, '0);

    random_words(300, 0);
    set_threshold(29'h1FFF_FFFF);
    random_words(250, 1);
    set_threshold(29'd512);
    random_words(300, 2);
    // rebuild before every update
    set_threshold(29'd0);
    random_words(15, 3);
    set_threshold(29'd1);
    random_words(15, 0);
    set_threshold(count_t'($urandom_range(600, 4000)));
    random_words(300, 3);
    set_threshold(29'd700);
    random_words(300, 1);
    set_threshold(ThreshReset);
    random_words(400, 2);

    drain();
    $display("%0d encodes and %0d decodes checked (%0d words), %0d threshold settings",
             encodes, decodes, words_checked, settings);
    $display("idle and stall phases exercised on both channels, rescaling at low thresholds");
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
